FILE: hdl/sorted_kmer_count_merge_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted k-mer count merge unit
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_KMER_COUNT_MERGE_UNIT_ASSERT_SVH
`define SORTED_KMER_COUNT_MERGE_UNIT_ASSERT_SVH

`ifndef SYNTH

// check prop on every clock edge while reset is released
`define SKCM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("skcm assertion failed");

// check prop on every clock edge, reset included
`define SKCM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("skcm assertion failed");

`else

`define SKCM_ASSERT(lbl, clk, rstn, prop)
`define SKCM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: hdl/skcm_pkg.sv
// ----------------------------------------------------------------------------
// skcm_pkg
// Shared widths and the queued record type of the k-mer count merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skcm_pkg;

    localparam int SRC_W   = 4;
    localparam int KEY_W   = 64;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 5;
    localparam int ROW_MAX = 16;
    localparam int DATA_W  = 96;
    localparam int USER_W  = 5;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
        logic             ended;
    } rec_t;

endpackage

`default_nettype wire

FILE: hdl/skcm_front.sv
// ----------------------------------------------------------------------------
// skcm_front
// Accepts input transactions and queues them in a two-entry queue for the
// merge engine.
// ----------------------------------------------------------------------------
`default_nettype none

module skcm_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire skcm_pkg::rec_t                s_rec,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output skcm_pkg::rec_t                     q_rec
);

    localparam logic [1:0] Q_FULL = 2'd2;

    skcm_pkg::rec_t q_mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push;
    logic           pop;

    assign s_ready = (fill_reg != Q_FULL);
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_rec   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= s_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/skcm_back.sv
// ----------------------------------------------------------------------------
// skcm_back
// Merge engine: holds one head record per source, scans the heads for the
// minimum key and emits one result per source from a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module skcm_back #(
    parameter int DEPTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [skcm_pkg::CFG_W-1:0]    src_used,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire skcm_pkg::rec_t                q_rec,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [skcm_pkg::KEY_W-1:0]         m_key,
    output logic [skcm_pkg::SRC_W-1:0]         m_col,
    output logic [skcm_pkg::CNT_W-1:0]         m_cnt,
    output logic                               m_last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] FSM_IDLE      = 3'd0;
    localparam logic [2:0] FSM_CHECK     = 3'd1;
    localparam logic [2:0] FSM_SCAN      = 3'd2;
    localparam logic [2:0] FSM_SCAN_LAST = 3'd3;
    localparam logic [2:0] FSM_EMIT      = 3'd4;

    localparam logic [1:0] HS_WAIT = 2'd0;
    localparam logic [1:0] HS_HOLD = 2'd1;
    localparam logic [1:0] HS_END  = 2'd2;

    logic [skcm_pkg::KEY_W-1:0] key_mem [DEPTH];
    logic [skcm_pkg::CNT_W-1:0] cnt_mem [DEPTH];
    logic [skcm_pkg::KEY_W-1:0] rd_key_reg;
    logic [skcm_pkg::CNT_W-1:0] rd_cnt_reg;
    logic [IDX_W-1:0]           rd_addr;
    logic [IDX_W-1:0]           wr_addr;
    logic                       mem_we;

    logic [1:0]                 status_reg [DEPTH];
    logic [1:0]                 status_next [DEPTH];
    logic [2:0]                 state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]           cmp_idx_reg, cmp_idx_next;
    logic                       min_valid_reg, min_valid_next;
    logic [skcm_pkg::KEY_W-1:0] min_key_reg, min_key_next;

    logic                       m_valid_reg, m_valid_next;
    logic [skcm_pkg::KEY_W-1:0] m_key_reg, m_key_next;
    logic [skcm_pkg::SRC_W-1:0] m_col_reg, m_col_next;
    logic [skcm_pkg::CNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic                       m_last_reg, m_last_next;

    logic                       waiting;
    logic                       holding;
    logic                       last_idx;
    logic                       load;
    logic                       hit;
    logic                       in_range;

    assign q_ready  = (state_reg == FSM_IDLE);
    assign wr_addr  = q_rec.src[IDX_W-1:0];
    assign in_range = ({1'b0, q_rec.src} < src_used);
    assign mem_we   = (state_reg == FSM_IDLE) && q_valid && in_range
                      && (status_reg[wr_addr] == HS_WAIT) && !q_rec.ended;
    assign last_idx = (skcm_pkg::CFG_W'(idx_reg) == (src_used - 5'd1));
    assign load     = !m_valid_reg || m_ready;
    assign hit      = (status_reg[idx_reg] == HS_HOLD) && (rd_key_reg == min_key_reg);

    assign m_valid = m_valid_reg;
    assign m_key   = m_key_reg;
    assign m_col   = m_col_reg;
    assign m_cnt   = m_cnt_reg;
    assign m_last  = m_last_reg;

    always_comb begin
        waiting = 1'b0;
        holding = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (skcm_pkg::CFG_W'(i) < src_used) begin
                if (status_reg[i] == HS_WAIT) begin
                    waiting = 1'b1;
                end
                if (status_reg[i] == HS_HOLD) begin
                    holding = 1'b1;
                end
            end
        end
    end

    always_comb begin
        status_next    = status_reg;
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        min_valid_next = min_valid_reg;
        min_key_next   = min_key_reg;
        m_valid_next   = m_valid_reg;
        m_key_next     = m_key_reg;
        m_col_next     = m_col_reg;
        m_cnt_next     = m_cnt_reg;
        m_last_next    = m_last_reg;
        rd_addr        = idx_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmp_valid_reg && (status_reg[cmp_idx_reg] == HS_HOLD)
            && (!min_valid_reg || (rd_key_reg < min_key_reg))) begin
            min_valid_next = 1'b1;
            min_key_next   = rd_key_reg;
        end

        unique case (state_reg)
            FSM_IDLE: begin
                if (q_valid) begin
                    if (in_range && (status_reg[wr_addr] == HS_WAIT)) begin
                        status_next[wr_addr] = q_rec.ended ? HS_END : HS_HOLD;
                    end
                    state_next = FSM_CHECK;
                end
            end
            FSM_CHECK: begin
                if (!waiting && holding) begin
                    state_next     = FSM_SCAN;
                    idx_next       = '0;
                    min_valid_next = 1'b0;
                end else begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_SCAN: begin
                rd_addr        = idx_reg;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = idx_reg;
                if (last_idx) begin
                    state_next = FSM_SCAN_LAST;
                    idx_next   = '0;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            FSM_SCAN_LAST: begin
                rd_addr        = '0;
                cmp_valid_next = 1'b0;
                state_next     = FSM_EMIT;
            end
            FSM_EMIT: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_key_next   = min_key_reg;
                    m_col_next   = skcm_pkg::SRC_W'(idx_reg);
                    m_cnt_next   = hit ? rd_cnt_reg : '0;
                    m_last_next  = last_idx;
                    if (hit) begin
                        status_next[idx_reg] = HS_WAIT;
                    end
                    if (last_idx) begin
                        state_next = FSM_IDLE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[wr_addr] <= q_rec.key;
            cnt_mem[wr_addr] <= q_rec.cnt;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_cnt_reg <= cnt_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        min_key_reg <= min_key_next;
        m_key_reg   <= m_key_next;
        m_col_reg   <= m_col_next;
        m_cnt_reg   <= m_cnt_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            min_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                status_reg[i] <= HS_WAIT;
            end
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            min_valid_reg <= min_valid_next;
            m_valid_reg   <= m_valid_next;
            status_reg    <= status_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sorted_kmer_count_merge_unit.sv
// An input that completes a row starts the merge engine on a row of n sources, n being the
// number of sources in use: a head scan through one memory read port, then one result per
// cycle while the output is not stalled. The engine takes one input at a time and takes no
// new input while it checks, scans or emits.
// A two-entry queue lets the input side accept while the engine scans or emits.
// Reset: synchronous, active-low aresetn; all sources wait for a record, sources_in_use = 16.
// ----------------------------------------------------------------------------
// sorted_kmer_count_merge_unit
// Merges sorted (k-mer key, count) streams of several sources into count rows.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_kmer_count_merge_unit_assert.svh"

module sorted_kmer_count_merge_unit #(
    parameter int NUM_SOURCES = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [skcm_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // kmer_key [63:0], kmer_count [95:64]
    input  wire logic [skcm_pkg::DATA_W-1:0]    s_axis_tdata,
    // source [3:0], source_ended [4]
    input  wire logic [skcm_pkg::USER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // row_key [63:0], column_count [95:64]
    output logic [skcm_pkg::DATA_W-1:0]         m_axis_tdata,
    // column [3:0]
    output logic [skcm_pkg::SRC_W-1:0]          m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int DEPTH = (NUM_SOURCES < skcm_pkg::ROW_MAX) ? NUM_SOURCES
                                                             : skcm_pkg::ROW_MAX;
    localparam logic [skcm_pkg::CFG_W-1:0] CFG_RESET = 5'd16;

    logic [skcm_pkg::CFG_W-1:0] sources_in_use_reg;
    logic [skcm_pkg::CFG_W-1:0] src_used;
    skcm_pkg::rec_t             s_rec;
    skcm_pkg::rec_t             q_rec;
    logic                       q_valid;
    logic                       q_ready;
    logic [skcm_pkg::KEY_W-1:0] m_key;
    logic [skcm_pkg::CNT_W-1:0] m_cnt;
    logic                       col_fire;
    logic [skcm_pkg::SRC_W-1:0] col_succ;
    logic                       out_stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sources_in_use_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            sources_in_use_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        priority if (sources_in_use_reg == '0) begin
            src_used = skcm_pkg::CFG_W'(1);
        end else if (sources_in_use_reg > skcm_pkg::CFG_W'(DEPTH)) begin
            src_used = skcm_pkg::CFG_W'(DEPTH);
        end else begin
            src_used = sources_in_use_reg;
        end
    end

    assign s_rec.src   = s_axis_tuser[3:0];
    assign s_rec.ended = s_axis_tuser[4];
    assign s_rec.key   = s_axis_tdata[63:0];
    assign s_rec.cnt   = s_axis_tdata[95:64];

    skcm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_rec    (s_rec),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_rec    (q_rec)
    );

    skcm_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .src_used (src_used),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_rec    (q_rec),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_key    (m_key),
        .m_col    (m_axis_tuser),
        .m_cnt    (m_cnt),
        .m_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {m_cnt, m_key};

    assign col_fire  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
    assign col_succ  = m_axis_tuser + 4'd1;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `SKCM_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_axis_tvalid)
    `SKCM_ASSERT(a_out_hold, aclk, aresetn, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))
    `SKCM_ASSERT(a_col_step, aclk, aresetn, $past(col_fire) |-> m_axis_tuser == $past(col_succ))

endmodule

`default_nettype wire
